// ----- rtl/iab_pkg.sv -----
// Shared constants for the interval atan2 bounds block.
// Holds the CORDIC arctangent table and the internal datapath widths.
// No dependencies.
package iab_pkg;

  // Coordinates are brought to a common scale of 2^40 before the rotations.
  localparam int PRESCALE_BITS = 40;

  // Width of the x and y rotation registers. This covers the prescaled input,
  // the CORDIC gain of about 1.65 and the sqrt(2) growth of a corner vector.
  localparam int XY_W = 44;

  // Width of the angle accumulator in 32-bit binary radians, with headroom
  // for the quarter-turn start and the sum of the table.
  localparam int Z_W = 34;

  // Number of entries in the arctangent table.
  localparam int ATAN_ENTRIES = 32;

  // atan(2^-i) in binary radians, pi = 2^31.
  localparam logic [31:0] ATAN_TABLE [0:ATAN_ENTRIES-1] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861,
    32'd10430,     32'd5215,      32'd2608,      32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81,
    32'd41,        32'd20,        32'd10,        32'd5,
    32'd3,         32'd1,         32'd1,         32'd0
  };

endpackage

// ----- rtl/interval_atan2_bounds_core.sv -----
// Top level of the interval atan2 bounds block.
// Depends on iab_pkg and on iab_cordic, of which it holds two instances.
//
// Usage: one input beat carries a box, y_low..y_high by x_low..x_high, in
// signed fixed point. One output beat carries the angle interval
// angle_low..angle_high that encloses atan2 over the box, in binary radians
// with pi at 2^(ANGLE_WIDTH-1), plus full_circle when the box meets the
// negative x axis (then the bounds are minus pi and saturated plus pi).
// Both channels use valid and stall; a beat moves when valid is high and
// stall is low.
// Each input beat passes through an input stage, one register stage per rotation
// step and an output stage in each of the two CORDIC pipelines (one per bound).
// Throughput is one box per cycle while the receiver does not stall.
// Reset clears all valid bits; the datapath registers are not reset.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and in_stall is raised, so no beat is dropped or repeated.
module interval_atan2_bounds_core #(
  parameter int COORD_WIDTH  = 16,
  parameter int ANGLE_WIDTH  = 16,
  parameter int CORDIC_STEPS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [COORD_WIDTH-1:0] y_low,
  input  logic signed [COORD_WIDTH-1:0] y_high,
  input  logic signed [COORD_WIDTH-1:0] x_low,
  input  logic signed [COORD_WIDTH-1:0] x_high,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [ANGLE_WIDTH-1:0] angle_low,
  output logic signed [ANGLE_WIDTH-1:0] angle_high,
  output logic                          full_circle
);
  import iab_pkg::*;

  // Pipeline depth: input stage, one stage per step, output stage.
  localparam int DEPTH = CORDIC_STEPS + 2;

  localparam logic signed [ANGLE_WIDTH-1:0] ANGLE_MIN = {1'b1, {(ANGLE_WIDTH-1){1'b0}}};
  localparam logic signed [ANGLE_WIDTH-1:0] ANGLE_MAX = {1'b0, {(ANGLE_WIDTH-1){1'b1}}};

  // The whole pipeline advances unless a finished result is held back.
  logic en;
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // Sign tests on the box as given; unordered bounds are not swapped.
  logic xlo_le0;
  logic xhi_ge0;
  logic ylo_ge0;
  logic ylo_le0;
  logic yhi_ge0;
  logic yhi_le0;
  logic full_in;

  assign xlo_le0 = x_low[COORD_WIDTH-1] || (x_low == '0);
  assign xhi_ge0 = !x_high[COORD_WIDTH-1];
  assign ylo_ge0 = !y_low[COORD_WIDTH-1];
  assign ylo_le0 = y_low[COORD_WIDTH-1] || (y_low == '0);
  assign yhi_ge0 = !y_high[COORD_WIDTH-1];
  assign yhi_le0 = y_high[COORD_WIDTH-1] || (y_high == '0);
  assign full_in = xlo_le0 && ylo_le0 && yhi_ge0;

  // Pick the corner that bounds the angle from above and from below.
  logic signed [COORD_WIDTH-1:0] hi_y;
  logic signed [COORD_WIDTH-1:0] hi_x;
  logic signed [COORD_WIDTH-1:0] lo_y;
  logic signed [COORD_WIDTH-1:0] lo_x;

  always_comb begin
    if (ylo_ge0) begin
      hi_y = xlo_le0 ? y_low : y_high;
      hi_x = x_low;
    end else if (xhi_ge0) begin
      hi_y = y_high;
      hi_x = yhi_ge0 ? x_low : x_high;
    end else begin
      hi_y = y_low;
      hi_x = x_high;
    end

    if (yhi_le0) begin
      lo_y = xlo_le0 ? y_high : y_low;
      lo_x = x_low;
    end else if (xhi_ge0) begin
      lo_y = y_low;
      lo_x = ylo_ge0 ? x_high : x_low;
    end else begin
      lo_y = y_high;
      lo_x = x_high;
    end
  end

  logic signed [ANGLE_WIDTH-1:0] lo_angle;
  logic signed [ANGLE_WIDTH-1:0] hi_angle;

  iab_cordic #(
    .COORD_WIDTH (COORD_WIDTH),
    .ANGLE_WIDTH (ANGLE_WIDTH),
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_lo (
    .clk  (clk),
    .en   (en),
    .y    (lo_y),
    .x    (lo_x),
    .angle(lo_angle)
  );

  iab_cordic #(
    .COORD_WIDTH (COORD_WIDTH),
    .ANGLE_WIDTH (ANGLE_WIDTH),
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_hi (
    .clk  (clk),
    .en   (en),
    .y    (hi_y),
    .x    (hi_x),
    .angle(hi_angle)
  );

  // Valid and full-circle flags travel beside the CORDIC stages.
  logic vld  [0:DEPTH-1];
  logic full [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < DEPTH; k++) begin
        vld[k] <= 1'b0;
      end
    end else if (en) begin
      vld[0] <= in_valid;
      for (int k = 1; k < DEPTH; k++) begin
        vld[k] <= vld[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      full[0] <= full_in;
      for (int k = 1; k < DEPTH; k++) begin
        full[k] <= full[k-1];
      end
    end
  end

  // A full-circle box overrides whatever the CORDIC pipelines produced.
  assign out_valid   = vld[DEPTH-1];
  assign full_circle = full[DEPTH-1];
  assign angle_low   = full[DEPTH-1] ? ANGLE_MIN : lo_angle;
  assign angle_high  = full[DEPTH-1] ? ANGLE_MAX : hi_angle;

endmodule

// ----- rtl/iab_cordic.sv -----
// Pipelined CORDIC vectoring unit: atan2 of one corner, one step per stage.
// Depends on iab_pkg for the arctangent table and datapath widths.
// It has CORDIC_STEPS + 2 register stages, all advanced by en.
module iab_cordic #(
  parameter int COORD_WIDTH  = 16,
  parameter int ANGLE_WIDTH  = 16,
  parameter int CORDIC_STEPS = 16
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic signed [COORD_WIDTH-1:0] y,
  input  logic signed [COORD_WIDTH-1:0] x,
  output logic signed [ANGLE_WIDTH-1:0] angle
);
  import iab_pkg::*;

  localparam int PRE_SHIFT = PRESCALE_BITS - COORD_WIDTH;
  localparam int SHIFT     = 32 - ANGLE_WIDTH;

  localparam logic signed [Z_W-1:0] Z_QUARTER = Z_W'(1) << 30;
  localparam logic signed [Z_W-1:0] Z_RND     = Z_W'(1) << ((SHIFT > 0) ? SHIFT - 1 : 0);
  localparam logic signed [Z_W-1:0] A_MAX     = (Z_W'(1) << (ANGLE_WIDTH - 1)) - Z_W'(1);
  localparam logic signed [Z_W-1:0] A_MIN     = -(Z_W'(1) << (ANGLE_WIDTH - 1));

  logic signed [XY_W-1:0] xs [0:CORDIC_STEPS];
  logic signed [XY_W-1:0] ys [0:CORDIC_STEPS];
  logic signed [Z_W-1:0]  zs [0:CORDIC_STEPS];
  logic                   org [0:CORDIC_STEPS];

  logic signed [XY_W-1:0] y_ext;
  logic signed [XY_W-1:0] x_ext;
  logic signed [XY_W-1:0] x_pre;
  logic signed [XY_W-1:0] y_pre;
  logic signed [Z_W-1:0]  z_pre;

  // Scale the corner and turn it into the right half plane.
  always_comb begin
    y_ext = XY_W'(y) <<< PRE_SHIFT;
    x_ext = XY_W'(x) <<< PRE_SHIFT;
    x_pre = x_ext;
    y_pre = y_ext;
    z_pre = '0;
    if (x_ext[XY_W-1]) begin
      if (!y_ext[XY_W-1]) begin
        x_pre = y_ext;
        y_pre = -x_ext;
        z_pre = Z_QUARTER;
      end else begin
        x_pre = -y_ext;
        y_pre = x_ext;
        z_pre = -Z_QUARTER;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xs[0]  <= x_pre;
      ys[0]  <= y_pre;
      zs[0]  <= z_pre;
      org[0] <= (x == '0) && (y == '0);
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    localparam logic signed [Z_W-1:0] T_I = Z_W'(ATAN_TABLE[i]);
    always_ff @(posedge clk) begin
      if (en) begin
        if (!ys[i][XY_W-1]) begin
          xs[i+1] <= xs[i] + (ys[i] >>> i);
          ys[i+1] <= ys[i] - (xs[i] >>> i);
          zs[i+1] <= zs[i] + T_I;
        end else begin
          xs[i+1] <= xs[i] - (ys[i] >>> i);
          ys[i+1] <= ys[i] + (xs[i] >>> i);
          zs[i+1] <= zs[i] - T_I;
        end
        org[i+1] <= org[i];
      end
    end
  end

  logic signed [Z_W-1:0] z_rnd;
  logic signed [Z_W-1:0] z_sat;

  if (SHIFT > 0) begin : g_round
    assign z_rnd = (zs[CORDIC_STEPS] + Z_RND) >>> SHIFT;
  end else begin : g_noround
    assign z_rnd = zs[CORDIC_STEPS];
  end

  always_comb begin
    z_sat = z_rnd;
    if (z_rnd > A_MAX) begin
      z_sat = A_MAX;
    end else if (z_rnd < A_MIN) begin
      z_sat = A_MIN;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      angle <= org[CORDIC_STEPS] ? '0 : z_sat[ANGLE_WIDTH-1:0];
    end
  end

endmodule

// ----- rtl/iab_checker.sv -----
// Port-level checks for the interval atan2 bounds block.
// Depends on interval_atan2_bounds_core, to which the bind below attaches it.
module iab_checker #(
  parameter int ANGLE_WIDTH = 16
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic signed [ANGLE_WIDTH-1:0] angle_low,
  input logic signed [ANGLE_WIDTH-1:0] angle_high,
  input logic                          full_circle
);

  localparam logic signed [ANGLE_WIDTH-1:0] ANGLE_MIN = {1'b1, {(ANGLE_WIDTH-1){1'b0}}};
  localparam logic signed [ANGLE_WIDTH-1:0] ANGLE_MAX = {1'b0, {(ANGLE_WIDTH-1){1'b1}}};

  // No result survives a reset.
  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid high right after reset");

  // A full-circle result always carries the extreme bounds.
  a_full_bounds: assert property (@(posedge clk) disable iff (rst)
    out_valid && full_circle |-> angle_low == ANGLE_MIN && angle_high == ANGLE_MAX)
    else $error("full circle result without extreme bounds");

  // A held result back-pressures the input side.
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |-> in_stall)
    else $error("input accepted while a result is held");

  // A stalled result stays put.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(angle_low) && $stable(angle_high)
      && $stable(full_circle))
    else $error("stalled result changed");

  // The input side is only stalled when the output side is.
  a_no_idle_stall: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_stall |-> out_valid && out_stall)
    else $error("input stalled without a held result");

endmodule

bind interval_atan2_bounds_core iab_checker #(
  .ANGLE_WIDTH(ANGLE_WIDTH)
) u_iab_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .angle_low  (angle_low),
  .angle_high (angle_high),
  .full_circle(full_circle)
);

// ----- test/interval_atan2_bounds_core_tb.sv -----
// Self-checking testbench for interval_atan2_bounds_core: directed boxes, then random ones.
// Depends on iab_pkg (arctangent table, prescale shift) and on the RTL of the block.
// A local CORDIC predictor computes the expected angle bounds of each accepted box.
module interval_atan2_bounds_core_tb;

  import iab_pkg::*;

  localparam int COORD_W = 16;
  localparam int ANGLE_W = 16;
  localparam int STEPS   = 16;

  // Random boxes after the directed table, and how many of the last ones run with
  // no idling on either side.
  localparam int RANDOM_BOXES = 830;
  localparam int CALM_TAIL    = 100;

  // Cycles without any beat on either channel before the run is declared hung.
  // The worst honest gap is the pipeline latency plus a few stall bursts.
  localparam int WATCHDOG_LIMIT = 2000;

  typedef struct packed {
    logic signed [COORD_W-1:0] y_low;
    logic signed [COORD_W-1:0] y_high;
    logic signed [COORD_W-1:0] x_low;
    logic signed [COORD_W-1:0] x_high;
  } box_t;

  typedef struct packed {
    logic signed [ANGLE_W-1:0] angle_low;
    logic signed [ANGLE_W-1:0] angle_high;
    logic                      full_circle;
  } bounds_t;

  // A directed row either carries its answer (typed) or leaves it to the predictor.
  typedef struct packed {
    box_t    box;
    logic    typed;
    bounds_t want;
  } dir_row_t;

  // Minus pi to saturated plus pi, with the flag set.
  localparam bounds_t FULL_RANGE = '{16'sh8000, 16'sh7fff, 1'b1};

  localparam int DIRECTED_ROWS = 21;

  // The directed table. Rows marked typed are full-circle boxes, whose answer is
  // fixed; all others are checked against the predictor.
  dir_row_t directed_boxes [DIRECTED_ROWS] = '{
    // Full circle: the origin, the whole plane, a flat box on the x axis,
    // a box touching the origin from below, and an unordered x interval.
    '{'{16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b1, FULL_RANGE},
    '{'{16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff}, 1'b1, FULL_RANGE},
    '{'{16'sd0, 16'sd0, -16'sd5, 16'sd7}, 1'b1, FULL_RANGE},
    '{'{-16'sd1, 16'sd0, 16'sd0, 16'sd0}, 1'b1, FULL_RANGE},
    '{'{-16'sd3, 16'sd3, 16'sd0, -16'sd100}, 1'b1, FULL_RANGE},
    // One box per quadrant and the straddling cases.
    '{'{16'sd100, 16'sd200, 16'sd300, 16'sd400}, 1'b0, '0},
    '{'{16'sd1, 16'sh7fff, 16'sh8000, -16'sd1}, 1'b0, '0},
    '{'{16'sh8000, -16'sd1, 16'sh8000, -16'sd1}, 1'b0, '0},
    '{'{-16'sd500, -16'sd1, 16'sd0, 16'sd1000}, 1'b0, '0},
    '{'{16'sh8000, 16'sh7fff, 16'sd1, 16'sh7fff}, 1'b0, '0},
    '{'{16'sd1, 16'sd10, -16'sd10, 16'sd10}, 1'b0, '0},
    '{'{-16'sd10, -16'sd1, -16'sd10, 16'sd10}, 1'b0, '0},
    // Corner extremes.
    '{'{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff}, 1'b0, '0},
    '{'{16'sh8000, 16'sh8000, 16'sd1, 16'sh7fff}, 1'b0, '0},
    '{'{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000}, 1'b0, '0},
    '{'{16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff}, 1'b0, '0},
    // A corner on the negative x axis saturates at plus pi; the unordered y
    // interval keeps the box clear of the full-circle test.
    '{'{16'sd0, -16'sd1, -16'sd100, -16'sd50}, 1'b0, '0},
    '{'{16'sd1, 16'sd1, 16'sh8000, 16'sh8000}, 1'b0, '0},
    // The origin as a corner: the lower bound becomes atan2(0, 0).
    '{'{16'sd5, 16'sd0, 16'sd0, 16'sd10}, 1'b0, '0},
    // Unordered y with x to the right, and a point on the positive y axis.
    '{'{16'sd100, -16'sd100, 16'sd50, 16'sd20}, 1'b0, '0},
    '{'{16'sd1, 16'sd1, 16'sd0, 16'sd0}, 1'b0, '0}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic signed [COORD_W-1:0] y_low    = '0;
  logic signed [COORD_W-1:0] y_high   = '0;
  logic signed [COORD_W-1:0] x_low    = '0;
  logic signed [COORD_W-1:0] x_high   = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic signed [ANGLE_W-1:0] angle_low;
  logic signed [ANGLE_W-1:0] angle_high;
  logic                      full_circle;

  // Bounds of every accepted box, oldest first, until its result beat arrives.
  bounds_t pending_bounds [$];

  int  errors      = 0;
  int  stall_left  = 0;
  int  quiet_edges = 0;
  // When clear, neither side inserts gaps or stalls.
  bit  idle_on     = 1'b1;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  interval_atan2_bounds_core #(
    .COORD_WIDTH  (COORD_W),
    .ANGLE_WIDTH  (ANGLE_W),
    .CORDIC_STEPS (STEPS)
  ) i_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .y_low       (y_low),
    .y_high      (y_high),
    .x_low       (x_low),
    .x_high      (x_high),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .angle_low   (angle_low),
    .angle_high  (angle_high),
    .full_circle (full_circle)
  );

  // Angle of the corner (y, x) in binary radians, rounded to ANGLE_W bits.
  // The corner is scaled up to 2^40 full scale, folded into the right half-plane
  // by a quarter turn when x is negative, and then rotated toward the x axis by
  // the shift-add steps while the turned angle is accumulated at pi = 2^31.
  function automatic logic signed [ANGLE_W-1:0] corner_angle(longint y, longint x);
    longint cx, cy, cz, dx, dy, t, amax, amin;
    amax = (longint'(1) <<< (ANGLE_W - 1)) - 1;
    amin = -amax - 1;
    if (x == 0 && y == 0) return '0;
    cx = x * (longint'(1) <<< (PRESCALE_BITS - COORD_W));
    cy = y * (longint'(1) <<< (PRESCALE_BITS - COORD_W));
    cz = 0;
    if (cx < 0) begin
      t = cx;
      if (cy >= 0) begin
        cx = cy;
        cy = -t;
        cz = longint'(1) <<< 30;
      end else begin
        cx = -cy;
        cy = t;
        cz = -(longint'(1) <<< 30);
      end
    end
    // Both updates use the coordinates from before the step.
    for (int i = 0; i < STEPS && i < ATAN_ENTRIES; i++) begin
      dx = cy >>> i;
      dy = cx >>> i;
      if (cy >= 0) begin
        cx = cx + dx;
        cy = cy - dy;
        cz = cz + longint'(ATAN_TABLE[i]);
      end else begin
        cx = cx - dx;
        cy = cy + dy;
        cz = cz - longint'(ATAN_TABLE[i]);
      end
    end
    // Round half up to the output width, then clamp; plus pi lands on amax.
    if (ANGLE_W < 32) cz = (cz + (longint'(1) <<< (31 - ANGLE_W))) >>> (32 - ANGLE_W);
    if (cz > amax) cz = amax;
    if (cz < amin) cz = amin;
    return cz[ANGLE_W-1:0];
  endfunction

  // Angle interval of a box. The bounds are compared exactly as given, so an
  // unordered interval is not swapped before the corners are picked.
  function automatic bounds_t bounds_of_box(box_t b);
    longint  ylo, yhi, xlo, xhi;
    bounds_t r;
    ylo = longint'(b.y_low);
    yhi = longint'(b.y_high);
    xlo = longint'(b.x_low);
    xhi = longint'(b.x_high);
    if (xlo <= 0 && ylo <= 0 && yhi >= 0) return FULL_RANGE;
    r.full_circle = 1'b0;
    if (ylo >= 0)
      r.angle_high = (xlo <= 0) ? corner_angle(ylo, xlo) : corner_angle(yhi, xlo);
    else if (xhi >= 0)
      r.angle_high = (yhi >= 0) ? corner_angle(yhi, xlo) : corner_angle(yhi, xhi);
    else
      r.angle_high = corner_angle(ylo, xhi);
    if (yhi <= 0)
      r.angle_low = (xlo <= 0) ? corner_angle(yhi, xlo) : corner_angle(ylo, xlo);
    else if (xhi >= 0)
      r.angle_low = (ylo >= 0) ? corner_angle(ylo, xhi) : corner_angle(ylo, xlo);
    else
      r.angle_low = corner_angle(yhi, xhi);
    return r;
  endfunction

  // A coordinate over the full range, or a narrow one near the axes where the
  // sign tests and the origin matter most.
  function automatic logic signed [COORD_W-1:0] pick_coord(bit narrow);
    int v;
    if (narrow) v = int'($urandom_range(0, 256)) - 128;
    else v = int'($urandom());
    return v[COORD_W-1:0];
  endfunction

  // Most random boxes are ordered. Some are forced into one half-plane so that
  // the corner selection is exercised rather than the full-circle exit, some
  // collapse to a point, and some are left raw and may be unordered.
  function automatic box_t random_box();
    box_t                      b;
    bit                        narrow;
    int                        kind;
    logic signed [COORD_W-1:0] tmp;
    narrow   = ($urandom_range(0, 2) == 0);
    b.y_low  = pick_coord(narrow);
    b.y_high = pick_coord(narrow);
    b.x_low  = pick_coord(narrow);
    b.x_high = pick_coord(narrow);
    kind     = $urandom_range(0, 9);
    case (kind)
      7: begin
        b.x_low[COORD_W-1]  = 1'b0;
        b.x_high[COORD_W-1] = 1'b0;
        if (b.x_low == 0) b.x_low = COORD_W'(1);
        if (b.x_high == 0) b.x_high = COORD_W'(1);
      end
      8: begin
        b.y_low[COORD_W-1]  = 1'($urandom_range(0, 1));
        b.y_high[COORD_W-1] = b.y_low[COORD_W-1];
        if (b.y_low == 0) b.y_low = COORD_W'(1);
        if (b.y_high == 0) b.y_high = COORD_W'(1);
      end
      9: begin
        b.y_high = b.y_low;
        b.x_high = b.x_low;
      end
      default: ;
    endcase
    if (kind >= 3) begin
      if (b.y_low > b.y_high) begin
        tmp      = b.y_low;
        b.y_low  = b.y_high;
        b.y_high = tmp;
      end
      if (b.x_low > b.x_high) begin
        tmp      = b.x_low;
        b.x_low  = b.x_high;
        b.x_high = tmp;
      end
    end
    return b;
  endfunction

  // Present one box and hold it until the block takes the beat. A short gap may
  // come first; valid is dropped only for the gap, so it is never lowered and
  // raised within one edge. in_stall is read right after the edge, before any
  // register of the block has updated, so it is the value the edge saw.
  task automatic send_box(box_t b, logic typed, bounds_t want);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    y_low    <= b.y_low;
    y_high   <= b.y_high;
    x_low    <= b.x_low;
    x_high   <= b.x_high;
    do @(posedge clk); while (in_stall);
    pending_bounds.push_back(typed ? want : bounds_of_box(b));
  endtask

  // Compare one result beat, field by field, with the oldest pending bounds.
  task automatic check_result();
    bounds_t want;
    if (pending_bounds.size() == 0) begin
      errors++;
      $display("%0t: result beat with no box pending: angle_low %0d angle_high %0d fc %0b",
               $time, angle_low, angle_high, full_circle);
    end else begin
      want = pending_bounds.pop_front();
      if (angle_low !== want.angle_low) begin
        errors++;
        $display("%0t: angle_low expected %0d got %0d", $time, want.angle_low, angle_low);
      end
      if (angle_high !== want.angle_high) begin
        errors++;
        $display("%0t: angle_high expected %0d got %0d", $time, want.angle_high, angle_high);
      end
      if (full_circle !== want.full_circle) begin
        errors++;
        $display("%0t: full_circle expected %0b got %0b", $time, want.full_circle,
                 full_circle);
      end
    end
  endtask

  // Receiver: check each result beat and stall the output side in bursts.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) check_result();
      if (stall_left != 0) begin
        out_stall  <= 1'b1;
        stall_left <= stall_left - 1;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        out_stall  <= 1'b1;
        stall_left <= $urandom_range(0, 2);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog: any beat on either channel restarts the count.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_edges <= 0;
    end else if (quiet_edges >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_edges <= quiet_edges + 1;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_boxes[i])
      send_box(directed_boxes[i].box, directed_boxes[i].typed, directed_boxes[i].want);

    // Idling is switched on and off in spells of fifty boxes, and stays off for
    // the tail so the pipeline also runs back to back at full rate.
    for (int n = 0; n < RANDOM_BOXES; n++) begin
      if (n >= RANDOM_BOXES - CALM_TAIL) idle_on = 1'b0;
      else if (n % 50 == 0) idle_on = ($urandom_range(0, 3) != 0);
      send_box(random_box(), 1'b0, '0);
    end
    in_valid <= 1'b0;

    // Drain, then leave room for any stray beat past the pipeline depth.
    while (pending_bounds.size() != 0) @(posedge clk);
    repeat (STEPS + 8) @(posedge clk);

    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
